/* rtl/mcpi_pkg.sv */
// Shared types, widths and constants for the motor current PI loop.
// Used by mcpi_cmd and motor_current_pi_loop; depends on nothing else.
package mcpi_pkg;

  // Binary point of the current and integrator scaling.
  localparam int FRAC_SHIFT = 6;

  // Field and datapath widths.
  localparam int CUR_W   = 16;  // phase current sample
  localparam int MEAS_W  = 17;  // selected and signed current
  localparam int ERR_W   = 18;  // target minus measured
  localparam int GAIN_W  = 16;  // kp and ki
  localparam int SHIFT_W = 4;   // extra shift registers
  localparam int LIM_W   = 15;  // integrator limit register
  localparam int INTEG_W = 23;  // integrator state
  localparam int PPROD_W = 35;  // -kp * error
  localparam int IPROD_W = 34;  // ki * error
  localparam int ISUM_W  = 35;  // integrator plus ki * error
  localparam int CMD_W   = 16;  // drive command
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP       = 3'd0,
    REG_KP_SHIFT = 3'd1,
    REG_KI       = 3'd2,
    REG_KI_SHIFT = 3'd3,
    REG_KI_LIMIT = 3'd4,
    REG_TARGET   = 3'd5
  } cfg_reg_t;

  // Hall decode table, one bit per hall state (bit n is state n).
  localparam logic [7:0] HALL_PICK_B = 8'b0001_1100;  // states 2, 3, 4 use phase B
  localparam logic [7:0] HALL_NEG    = 8'b0101_0000;  // states 4, 6 invert the sample
  localparam logic [7:0] HALL_ZERO   = 8'b1000_0001;  // states 0, 7 give no current

  // Picks the phase sample for a hall state and applies its sign.
  function automatic logic signed [MEAS_W-1:0] hall_measure(
    input logic signed [CUR_W-1:0] ia,
    input logic signed [CUR_W-1:0] ib,
    input logic        [2:0]       hall
  );
    logic signed [MEAS_W-1:0] pick;
    begin
      pick = HALL_PICK_B[hall] ? MEAS_W'(ib) : MEAS_W'(ia);
      if (HALL_ZERO[hall]) begin
        hall_measure = '0;
      end else if (HALL_NEG[hall]) begin
        hall_measure = -pick;
      end else begin
        hall_measure = pick;
      end
    end
  endfunction

endpackage

/* rtl/motor_current_pi_loop.sv */
// Motor current PI loop: an input register and a result register with the whole
// calculation in one combinational pass between them.
// A beat moves from the input register to the result register; the integrator add and clamp
// are combinational. Throughput: one beat per cycle unless the output stalls.
// The input stalls only while a result waits on the output and the input register is full.
// Synchronous active-high reset clears the configuration registers, the integrator and the valid bits.
// Depends on mcpi_pkg and mcpi_cmd.
module motor_current_pi_loop (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_write,
  input  logic        [mcpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [mcpi_pkg::CFG_DATA_W-1:0] cfg_data,
  // Sample channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mcpi_pkg::CUR_W-1:0]     phase_a_current,
  input  logic signed [mcpi_pkg::CUR_W-1:0]     phase_b_current,
  input  logic        [2:0]                     hall_bits,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mcpi_pkg::CMD_W-1:0]     drive_command,
  output logic signed [mcpi_pkg::MEAS_W-1:0]    measured_current
);

  // Configuration registers.
  logic signed [mcpi_pkg::GAIN_W-1:0]  kp;
  logic        [mcpi_pkg::SHIFT_W-1:0] prop_shift;
  logic signed [mcpi_pkg::GAIN_W-1:0]  ki;
  logic        [mcpi_pkg::SHIFT_W-1:0] integ_shift;
  logic        [mcpi_pkg::LIM_W-1:0]   integ_limit;
  logic signed [mcpi_pkg::CUR_W-1:0]   target;

  // Input register valid bit and ready terms.
  logic v1;
  logic rdy1, rdy2;

  // Input register.
  logic signed [mcpi_pkg::CUR_W-1:0]   s1_ia;
  logic signed [mcpi_pkg::CUR_W-1:0]   s1_ib;
  logic        [2:0]                   s1_hall;
  // Integrator state.
  logic signed [mcpi_pkg::INTEG_W-1:0] integ;

  // Combinational values between the input and result registers.
  logic signed [mcpi_pkg::MEAS_W-1:0]  meas_next;
  logic signed [mcpi_pkg::ERR_W-1:0]   err_next;
  logic signed [mcpi_pkg::MEAS_W:0]    neg_kp;
  logic signed [mcpi_pkg::PPROD_W-1:0] pprod_next;
  logic signed [mcpi_pkg::IPROD_W-1:0] iprod_next;
  logic signed [mcpi_pkg::ISUM_W-1:0]  sum_full;
  logic signed [mcpi_pkg::ISUM_W-1:0]  lim_pos;
  logic signed [mcpi_pkg::ISUM_W-1:0]  lim_neg;
  logic signed [mcpi_pkg::INTEG_W-1:0] integ_next;
  logic signed [mcpi_pkg::CMD_W-1:0]   cmd_next;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp          <= '0;
      prop_shift  <= '0;
      ki          <= '0;
      integ_shift <= '0;
      integ_limit <= '0;
      target      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mcpi_pkg::REG_KP:       kp          <= cfg_data;
        mcpi_pkg::REG_KP_SHIFT: prop_shift  <= cfg_data[mcpi_pkg::SHIFT_W-1:0];
        mcpi_pkg::REG_KI:       ki          <= cfg_data;
        mcpi_pkg::REG_KI_SHIFT: integ_shift <= cfg_data[mcpi_pkg::SHIFT_W-1:0];
        mcpi_pkg::REG_KI_LIMIT: integ_limit <= cfg_data[mcpi_pkg::LIM_W-1:0];
        mcpi_pkg::REG_TARGET:   target      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: a register may load when it is empty or is moving on.
  assign rdy2     = !out_valid || !out_stall;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)  v1        <= in_valid;
      if (rdy2)  out_valid <= v1;
    end
  end

  // Hall decode and error.
  assign meas_next = mcpi_pkg::hall_measure(s1_ia, s1_ib, s1_hall);
  assign err_next  = mcpi_pkg::ERR_W'(target) - mcpi_pkg::ERR_W'(meas_next);

  // Gain products; kp is negated at MEAS_W + 1 (18) bits so the most negative gain holds.
  assign neg_kp     = -(mcpi_pkg::MEAS_W + 1)'(kp);
  assign pprod_next = neg_kp * err_next;
  assign iprod_next = ki * err_next;

  // Integrator update at full width, then clamp to plus or minus limit << 6.
  assign sum_full = mcpi_pkg::ISUM_W'(integ) + mcpi_pkg::ISUM_W'(iprod_next);
  assign lim_pos  = $signed(mcpi_pkg::ISUM_W'({integ_limit, {mcpi_pkg::FRAC_SHIFT{1'b0}}}));
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (sum_full > lim_pos) begin
      integ_next = mcpi_pkg::INTEG_W'(lim_pos);
    end else if (sum_full < lim_neg) begin
      integ_next = mcpi_pkg::INTEG_W'(lim_neg);
    end else begin
      integ_next = mcpi_pkg::INTEG_W'(sum_full);
    end
  end

  // Integrator state advances with each beat that moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (v1 && rdy2) begin
      integ <= integ_next;
    end
  end

  // Command scaling and saturation, using the updated integrator.
  mcpi_cmd u_cmd (
    .prop_prod   (pprod_next),
    .integ       (integ_next),
    .prop_shift  (prop_shift),
    .integ_shift (integ_shift),
    .cmd         (cmd_next)
  );

  // Payload registers, loaded as their stage accepts.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ia   <= phase_a_current;
      s1_ib   <= phase_b_current;
      s1_hall <= hall_bits;
    end
    if (rdy2) begin
      drive_command    <= cmd_next;
      measured_current <= meas_next;
    end
  end

endmodule

/* rtl/mcpi_cmd.sv */
// Drive command formation: scales the proportional product and the integrator,
// subtracts them and saturates to 16 bits signed. Depends on mcpi_pkg.
module mcpi_cmd (
  input  logic signed [mcpi_pkg::PPROD_W-1:0]  prop_prod,
  input  logic signed [mcpi_pkg::INTEG_W-1:0]  integ,
  input  logic        [mcpi_pkg::SHIFT_W-1:0]  prop_shift,
  input  logic        [mcpi_pkg::SHIFT_W-1:0]  integ_shift,
  output logic signed [mcpi_pkg::CMD_W-1:0]    cmd
);

  localparam int DIFF_W = mcpi_pkg::PPROD_W + 1;
  localparam logic signed [DIFF_W-1:0] CMD_MAX = DIFF_W'(32767);
  localparam logic signed [DIFF_W-1:0] CMD_MIN = -DIFF_W'(32768);

  logic        [4:0]                      p_amt;
  logic        [4:0]                      i_amt;
  logic signed [mcpi_pkg::PPROD_W-1:0]    p_term;
  logic signed [mcpi_pkg::INTEG_W-1:0]    i_term;
  logic signed [DIFF_W-1:0]               diff;

  // Both terms use arithmetic right shifts of six plus the configured amount.
  assign p_amt  = 5'(mcpi_pkg::FRAC_SHIFT) + {1'b0, prop_shift};
  assign i_amt  = 5'(mcpi_pkg::FRAC_SHIFT) + {1'b0, integ_shift};
  assign p_term = prop_prod >>> p_amt;
  assign i_term = integ >>> i_amt;
  assign diff   = DIFF_W'(p_term) - DIFF_W'(i_term);

  // Saturate the difference to the command range.
  always_comb begin
    if (diff > CMD_MAX) begin
      cmd = mcpi_pkg::CMD_W'(CMD_MAX);
    end else if (diff < CMD_MIN) begin
      cmd = mcpi_pkg::CMD_W'(CMD_MIN);
    end else begin
      cmd = mcpi_pkg::CMD_W'(diff);
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the motor current PI loop (hall decode, clamped
// integrator, saturated command). Depends on mcpi_pkg and the RTL under rtl/.
module tb_top;
  import mcpi_pkg::*;

  localparam int PIPE_LATENCY = 1;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 106;

  // Register indexes that the map leaves unused; writes there are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic signed [CUR_W-1:0] ia;
    logic signed [CUR_W-1:0] ib;
    logic        [2:0]       hall;
  } sample_t;

  typedef struct packed {
    logic signed [CMD_W-1:0]  cmd;
    logic signed [MEAS_W-1:0] meas;
  } loop_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CUR_W-1:0] phase_a_current = '0;
  logic signed [CUR_W-1:0] phase_b_current = '0;
  logic [2:0] hall_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CMD_W-1:0] drive_command;
  logic signed [MEAS_W-1:0] measured_current;

  // Shadow copy of the registers and of the integrator.
  logic signed [GAIN_W-1:0]  kp_gain = '0;
  logic        [SHIFT_W-1:0] prop_shift = '0;
  logic signed [GAIN_W-1:0]  ki_gain = '0;
  logic        [SHIFT_W-1:0] integ_shift = '0;
  logic        [LIM_W-1:0]   integ_limit = '0;
  logic signed [CUR_W-1:0]   target = '0;
  logic signed [INTEG_W-1:0] integ_acc = '0;

  sample_t      pending_samples[$];
  loop_result_t expected_results[$];

  logic sample_taken = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   in_idle_rate = 0;
  int   out_idle_rate = 0;
  int   fail_count = 0;
  int   result_count = 0;

  motor_current_pi_loop u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .phase_a_current  (phase_a_current),
    .phase_b_current  (phase_b_current),
    .hall_bits        (hall_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_command    (drive_command),
    .measured_current (measured_current)
  );

  always #4 clk = ~clk;

  // One step of the PI loop: decode the hall state, update the clamped
  // integrator and form the saturated command.
  function automatic loop_result_t pi_step(input sample_t s);
    logic signed [MEAS_W-1:0] meas;
    longint err;
    longint sum;
    longint lim;
    longint prop;
    longint cmd;
    loop_result_t r;
    case (s.hall)
      3'd1, 3'd5: meas = s.ia;
      3'd2, 3'd3: meas = s.ib;
      3'd4: begin
        meas = s.ib;
        meas = -meas;
      end
      3'd6: begin
        meas = s.ia;
        meas = -meas;
      end
      default: meas = '0;
    endcase
    err = longint'(target) - longint'(meas);
    sum = longint'(integ_acc) + longint'(ki_gain) * err;
    lim = longint'(integ_limit) << FRAC_SHIFT;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    integ_acc = INTEG_W'(sum);
    prop = -longint'(kp_gain) * err;
    cmd = (prop >>> (FRAC_SHIFT + prop_shift)) - (sum >>> (FRAC_SHIFT + integ_shift));
    if (cmd > 32767) cmd = 32767;
    if (cmd < -32768) cmd = -32768;
    r.cmd = CMD_W'(cmd);
    r.meas = meas;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Writes one register of the block and of the shadow copy while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_KP:       kp_gain     = data[GAIN_W-1:0];
      REG_KP_SHIFT: prop_shift  = data[SHIFT_W-1:0];
      REG_KI:       ki_gain     = data[GAIN_W-1:0];
      REG_KI_SHIFT: integ_shift = data[SHIFT_W-1:0];
      REG_KI_LIMIT: integ_limit = data[LIM_W-1:0];
      REG_TARGET:   target      = data[CUR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every beat is sent and every result has come back, then lets
  // the pipeline settle. The check runs at the rising edge, where the driver
  // never takes a new sample from the queue.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || (in_valid && !sample_taken) ||
           expected_results.size() != 0);
    repeat (PIPE_LATENCY * 4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Upper bits are random so that the register width is exercised as well.
  function automatic logic [CFG_DATA_W-1:0] pick_shift();
    logic [SHIFT_W-1:0] sh;
    case ($urandom_range(0, 3))
      0: sh = '0;
      1: sh = '1;
      default: sh = SHIFT_W'($urandom_range(0, 15));
    endcase
    return {12'($urandom), sh};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    logic [LIM_W-1:0] lim;
    case ($urandom_range(0, 4))
      0: lim = '0;
      1: lim = '1;
      2: lim = LIM_W'($urandom_range(1, 300));
      default: lim = LIM_W'($urandom);
    endcase
    return {1'($urandom), lim};
  endfunction

  task automatic configure_random();
    write_reg(REG_KP, pick_gain());
    write_reg(REG_KP_SHIFT, pick_shift());
    write_reg(REG_KI, pick_gain());
    write_reg(REG_KI_SHIFT, pick_shift());
    write_reg(REG_KI_LIMIT, pick_limit());
    write_reg(REG_TARGET, pick_gain());
    if ($urandom_range(0, 1) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, 16'($urandom));
  endtask

  function automatic logic signed [CUR_W-1:0] rand_current(input logic signed [CUR_W-1:0] near);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 127)) - 16'd64;
      4, 5: return near;
      6: return -near;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic signed [CUR_W-1:0] ia,
                             input logic signed [CUR_W-1:0] ib, input logic [2:0] hall);
    sample_t s;
    s.ia = ia;
    s.ib = ib;
    s.hall = hall;
    pending_samples.push_back(s);
  endtask

  // Random samples; about three in ten currents lie near the target or its negation, so that the
  // integrator also moves in small steps short of its clamp.
  task automatic push_random_samples(input int count);
    logic signed [CUR_W-1:0] near;
    repeat (count) begin
      near = target ^ 16'($urandom_range(0, 15));
      push_sample(rand_current(near), rand_current(near), 3'($urandom_range(0, 7)));
    end
  endtask

  // Sample driver: holds a stalled beat, otherwise idles in bursts or sends
  // the next pending sample.
  always @(negedge clk) begin
    sample_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !sample_taken) begin
      // Beat still waiting for acceptance.
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (pending_samples.size() != 0 && in_idle_rate != 0 &&
                 $urandom_range(1, in_idle_rate) == 1) begin
      in_valid <= 1'b0;
      in_gap = $urandom_range(0, 12);
    end else if (pending_samples.size() != 0) begin
      cur = pending_samples.pop_front();
      in_valid        <= 1'b1;
      phase_a_current <= cur.ia;
      phase_b_current <= cur.ib;
      hall_bits       <= cur.hall;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side back pressure in bursts.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if (out_idle_rate != 0 && $urandom_range(1, out_idle_rate) == 1) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each accepted sample beat yields one expected result.
  always @(posedge clk) begin
    sample_t s;
    sample_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      s.ia = phase_a_current;
      s.ib = phase_b_current;
      s.hall = hall_bits;
      expected_results.push_back(pi_step(s));
    end
  end

  // Result monitor: compares each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    loop_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", result_count));
      end else begin
        want = expected_results.pop_front();
        if (drive_command !== want.cmd)
          report_mismatch($sformatf("result %0d drive_command got %0d want %0d",
                                    result_count, drive_command, want.cmd));
        if (measured_current !== want.meas)
          report_mismatch($sformatf("result %0d measured_current got %0d want %0d",
                                    result_count, measured_current, want.meas));
      end
      result_count++;
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A few samples with every register at its reset value.
    push_sample(16'h7FFF, 16'h8000, 3'd1);
    push_sample(16'h8000, 16'h7FFF, 3'd4);
    push_sample(16'h1234, 16'h8000, 3'd6);
    push_sample(16'h0000, 16'h0000, 3'd0);
    wait_drained();

    // Most negative kp, extreme ki and limit; every hall state with full-scale
    // currents, including negation of the most negative sample.
    write_reg(REG_KP, 16'h8000);
    write_reg(REG_KP_SHIFT, 16'h0000);
    write_reg(REG_KI, 16'h7FFF);
    write_reg(REG_KI_SHIFT, 16'h0000);
    write_reg(REG_KI_LIMIT, 16'h7FFF);
    write_reg(REG_TARGET, 16'h8000);
    write_reg(REG_UNMAPPED_HI, 16'hFFFF);
    @(posedge clk);
    for (int h = 0; h < 8; h++) push_sample(16'h8000, 16'h7FFF, 3'(h));
    for (int h = 0; h < 8; h++) push_sample(16'h7FFF, 16'h8000, 3'(h));
    push_sample(16'h0000, 16'h0000, 3'd3);
    push_sample(16'h0001, 16'hFFFF, 3'd5);
    push_sample(16'hFFFF, 16'h0001, 3'd2);
    push_sample(16'h0000, 16'h0000, 3'd7);
    wait_drained();

    // Random phases, the first two at opposite register extremes and the last
    // one without any idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_idle_rate = 0;
      out_idle_rate = 0;
      if (ph == 0) begin
        write_reg(REG_KP, 16'h7FFF);
        write_reg(REG_KP_SHIFT, 16'hFFFF);
        write_reg(REG_KI, 16'h8000);
        write_reg(REG_KI_SHIFT, 16'h000F);
        write_reg(REG_KI_LIMIT, 16'h0000);
        write_reg(REG_TARGET, 16'h7FFF);
        write_reg(REG_UNMAPPED_LO, 16'hA5A5);
      end else if (ph == 1) begin
        write_reg(REG_KP, 16'h8000);
        write_reg(REG_KP_SHIFT, 16'h0000);
        write_reg(REG_KI, 16'h7FFF);
        write_reg(REG_KI_SHIFT, 16'hFFF0);
        write_reg(REG_KI_LIMIT, 16'hFFFF);
        write_reg(REG_TARGET, 16'h0000);
      end else begin
        configure_random();
      end
      if (ph != RANDOM_PHASES - 1) begin
        case ($urandom_range(0, 3))
          0: in_idle_rate = 0;
          1: in_idle_rate = 3;
          default: in_idle_rate = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 3))
          0: out_idle_rate = 0;
          1: out_idle_rate = 3;
          default: out_idle_rate = $urandom_range(2, 12);
        endcase
      end
      @(posedge clk);
      push_random_samples(ITEMS_PER_PHASE);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* motor_current_pi_loop.f */
rtl/mcpi_pkg.sv
rtl/mcpi_cmd.sv
rtl/motor_current_pi_loop.sv
dv/tb_top.sv
